[rtl/core/hga_pkg.sv]
// ----------------------------------------------------------------------------
// hga_pkg
// Shared types and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hga_pkg;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 8;
  localparam int GEN_W  = 16;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REVIVE  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_ALIVE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_LIVE      = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  entity_index;
    logic [GEN_W-1:0]  entity_generation;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  out_index;
    logic [GEN_W-1:0]  out_generation;
    logic              is_live;
    logic [CNT_W-1:0]  live_count;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/core/hga_ram.sv]
// ----------------------------------------------------------------------------
// hga_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/generational_handle_allocator.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out slot handles made of an index and a generation, with destroy,
// liveness query, lookup and exact revive, under a small sequencer.
// ----------------------------------------------------------------------------
// One beat is taken at a time; the input stalls until its result sits in the
// output register, and the next beat may be taken while that result waits.
// A create that appends a fresh slot, a create on a full table, an unknown
// kind and any beat rejected on its index alone go straight to the output
// step; destroy, query and lookup of a used slot first wait for the
// registered read of the slot table; a create that reuses a freed slot reads
// the free stack and then the slot table, each a RAM with one registered
// read port. Revive checks the slot table when its slot is already in use,
// appends any skipped slots one at a time, pushing each onto the free stack,
// and then compacts the free stack one entry at a time through its only
// read port, reading an entry and then comparing it with its index. A
// stalled output register holds the block in its last step until it drains,
// and the input is ready again as soon as the result is loaded. The slot
// table keeps the alive bit next to the generation and needs no clearing after
// reset, since its read data is only used for slots below the used count.
`default_nettype none

module generational_handle_allocator #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hga_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hga_pkg::out_beat_t     out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = GEN_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR_GEN,
    ST_CR_SET,
    ST_CHECK,
    ST_RV_GROW,
    ST_RV_RD,
    ST_RV_CMP,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                 siu_r, siu_nxt;
  logic [CW-1:0]                 fd_r, fd_nxt;
  logic [CW-1:0]                 alive_r, alive_nxt;
  logic [CW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [hga_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [hga_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [GEN_BITS-1:0]           gen_r, gen_nxt;
  logic [IW-1:0]                 slot_r, slot_nxt;
  logic [hga_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic [IW-1:0]                 oidx_r, oidx_nxt;
  logic [GEN_BITS-1:0]           ogen_r, ogen_nxt;
  logic                          live_r, live_nxt;
  logic                          out_valid_r, out_valid_nxt;
  hga_pkg::out_beat_t            out_data_r, out_data_nxt;

  logic          tbl_wr_en;
  logic [IW-1:0] tbl_wr_addr;
  logic [TW-1:0] tbl_wr_data;
  logic [IW-1:0] tbl_rd_addr;
  logic [TW-1:0] tbl_rd_data;
  logic          fs_wr_en;
  logic [IW-1:0] fs_wr_addr;
  logic [IW-1:0] fs_wr_data;
  logic [IW-1:0] fs_rd_addr;
  logic [IW-1:0] fs_rd_data;

  logic [GEN_BITS+15:0] gen_in_wide;
  logic [GEN_BITS+15:0] ogen_wide;
  logic [IW+7:0]        oidx_wide;
  logic [CW+8:0]        count_wide;
  logic [31:0]          idx32_in;
  logic [31:0]          idx32_r;
  logic                 tbl_alive;
  logic                 tbl_match;

  hga_ram #(
    .WIDTH (TW),
    .DEPTH (SLOTS)
  ) u_slot_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  hga_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_free_stack (
    .clk     (clk),
    .wr_en   (fs_wr_en),
    .wr_addr (fs_wr_addr),
    .wr_data (fs_wr_data),
    .rd_addr (fs_rd_addr),
    .rd_data (fs_rd_data)
  );

  assign gen_in_wide = {{GEN_BITS{1'b0}}, in_data.entity_generation};
  assign ogen_wide   = {16'd0, ogen_r};
  assign oidx_wide   = {8'd0, oidx_r};
  assign count_wide  = {9'd0, alive_r};
  assign idx32_in    = 32'(in_data.entity_index);
  assign idx32_r     = 32'(idx_r);
  assign tbl_alive   = tbl_rd_data[GEN_BITS];
  assign tbl_match   = tbl_rd_data[GEN_BITS-1:0] == gen_r;

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    siu_nxt       = siu_r;
    fd_nxt        = fd_r;
    alive_nxt     = alive_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    gen_nxt       = gen_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    oidx_nxt      = oidx_r;
    ogen_nxt      = ogen_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = '0;
    tbl_wr_data   = '0;
    tbl_rd_addr   = '0;
    fs_wr_en      = 1'b0;
    fs_wr_addr    = '0;
    fs_wr_data    = '0;
    fs_rd_addr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          idx_nxt    = in_data.entity_index;
          gen_nxt    = gen_in_wide[GEN_BITS-1:0];
          status_nxt = hga_pkg::STAT_OK;
          oidx_nxt   = '0;
          ogen_nxt   = '0;
          live_nxt   = 1'b0;
          tbl_rd_addr = IW'(in_data.entity_index);
          state_nxt  = ST_DONE;
          unique case (in_data.kind)
            hga_pkg::KIND_CREATE: begin
              if (fd_r != '0) begin
                fs_rd_addr = IW'(fd_r - 1'b1);
                fd_nxt     = fd_r - 1'b1;
                state_nxt  = ST_CR_GEN;
              end else if (32'(siu_r) < 32'(SLOTS)) begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = siu_r[IW-1:0];
                tbl_wr_data = {1'b1, {GEN_BITS{1'b0}}};
                oidx_nxt    = siu_r[IW-1:0];
                siu_nxt     = siu_r + 1'b1;
                alive_nxt   = alive_r + 1'b1;
              end else begin
                status_nxt = hga_pkg::STAT_FULL;
              end
            end
            hga_pkg::KIND_DESTROY, hga_pkg::KIND_QUERY: begin
              if (idx32_in < 32'(siu_r)) begin
                state_nxt = ST_CHECK;
              end else begin
                status_nxt = hga_pkg::STAT_NOT_ALIVE;
              end
            end
            hga_pkg::KIND_LOOKUP: begin
              if (idx32_in < 32'(siu_r)) begin
                state_nxt = ST_CHECK;
              end else begin
                status_nxt = hga_pkg::STAT_RANGE;
              end
            end
            hga_pkg::KIND_REVIVE: begin
              if (idx32_in >= 32'(SLOTS)) begin
                status_nxt = hga_pkg::STAT_RANGE;
              end else if (idx32_in < 32'(siu_r)) begin
                state_nxt = ST_CHECK;
              end else begin
                state_nxt = ST_RV_GROW;
              end
            end
            default: begin
              status_nxt = hga_pkg::STAT_OK;
            end
          endcase
        end
      end

      ST_CR_GEN: begin
        tbl_rd_addr = fs_rd_data;
        slot_nxt    = fs_rd_data;
        state_nxt   = ST_CR_SET;
      end

      ST_CR_SET: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = slot_r;
        tbl_wr_data = {1'b1, tbl_rd_data[GEN_BITS-1:0]};
        oidx_nxt    = slot_r;
        ogen_nxt    = tbl_rd_data[GEN_BITS-1:0];
        alive_nxt   = alive_r + 1'b1;
        state_nxt   = ST_DONE;
      end

      ST_CHECK: begin
        state_nxt = ST_DONE;
        unique case (kind_r)
          hga_pkg::KIND_DESTROY: begin
            if (tbl_alive && tbl_match) begin
              tbl_wr_en   = 1'b1;
              tbl_wr_addr = IW'(idx_r);
              tbl_wr_data = {1'b0, tbl_rd_data[GEN_BITS-1:0] + 1'b1};
              alive_nxt   = alive_r - 1'b1;
              if (32'(fd_r) < 32'(SLOTS)) begin
                fs_wr_en   = 1'b1;
                fs_wr_addr = fd_r[IW-1:0];
                fs_wr_data = IW'(idx_r);
                fd_nxt     = fd_r + 1'b1;
              end
            end else begin
              status_nxt = hga_pkg::STAT_NOT_ALIVE;
            end
          end
          hga_pkg::KIND_QUERY: begin
            if (tbl_alive && tbl_match) begin
              live_nxt = 1'b1;
            end else begin
              status_nxt = hga_pkg::STAT_NOT_ALIVE;
            end
          end
          hga_pkg::KIND_LOOKUP: begin
            if (tbl_alive) begin
              oidx_nxt = IW'(idx_r);
              ogen_nxt = tbl_rd_data[GEN_BITS-1:0];
            end else begin
              status_nxt = hga_pkg::STAT_NOT_ALIVE;
            end
          end
          hga_pkg::KIND_REVIVE: begin
            if (tbl_alive) begin
              status_nxt = hga_pkg::STAT_LIVE;
            end else begin
              state_nxt = ST_RV_GROW;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_RV_GROW: begin
        if (32'(siu_r) < idx32_r) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = siu_r[IW-1:0];
          tbl_wr_data = '0;
          if (32'(fd_r) < 32'(SLOTS)) begin
            fs_wr_en   = 1'b1;
            fs_wr_addr = fd_r[IW-1:0];
            fs_wr_data = siu_r[IW-1:0];
            fd_nxt     = fd_r + 1'b1;
          end
          siu_nxt = siu_r + 1'b1;
        end else begin
          if (32'(siu_r) == idx32_r) begin
            siu_nxt = siu_r + 1'b1;
          end
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = IW'(idx_r);
          tbl_wr_data = {1'b1, gen_r};
          alive_nxt   = alive_r + 1'b1;
          rd_ptr_nxt  = '0;
          wr_ptr_nxt  = '0;
          state_nxt   = ST_RV_RD;
        end
      end

      ST_RV_RD: begin
        if (rd_ptr_r < fd_r) begin
          fs_rd_addr = rd_ptr_r[IW-1:0];
          state_nxt  = ST_RV_CMP;
        end else begin
          fd_nxt    = wr_ptr_r;
          state_nxt = ST_DONE;
        end
      end

      ST_RV_CMP: begin
        if (32'(fs_rd_data) != idx32_r) begin
          fs_wr_en   = 1'b1;
          fs_wr_addr = wr_ptr_r[IW-1:0];
          fs_wr_data = fs_rd_data;
          wr_ptr_nxt = wr_ptr_r + 1'b1;
        end
        rd_ptr_nxt = rd_ptr_r + 1'b1;
        state_nxt  = ST_RV_RD;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.out_index      = oidx_wide[7:0];
          out_data_nxt.out_generation = ogen_wide[15:0];
          out_data_nxt.is_live        = live_r;
          out_data_nxt.live_count     = count_wide[8:0];
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      siu_r       <= '0;
      fd_r        <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      siu_r       <= siu_nxt;
      fd_r        <= fd_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    gen_r      <= gen_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    oidx_r     <= oidx_nxt;
    ogen_r     <= ogen_nxt;
    live_r     <= live_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
